// ===== hw/rtl/network_acl_rule_classifier_unit_defines.svh =====
// Assertion macros shared by the classifier checker.
`ifndef NETWORK_ACL_RULE_CLASSIFIER_UNIT_DEFINES_SVH
`define NETWORK_ACL_RULE_CLASSIFIER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define NACL_ASSERT_NOW(label, cond, conseq, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (conseq)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define NACL_ASSERT_NEXT(label, cond, conseq, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (conseq)) \
		else $error(msg);

`endif

// ===== hw/rtl/nacl_pkg.sv =====
// Shared types, constants and helpers of the ACL rule classifier.
package nacl_pkg;

	localparam int MAX_RULES = 32;
	localparam int IDX_W     = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
	localparam int CNT_W     = $clog2(MAX_RULES + 1);

	localparam logic [1:0] PROTO_ALL   = 2'd3;
	localparam logic [5:0] FULL_PREFIX = 6'd32;

	typedef enum logic [1:0] {
		CMD_ADD   = 2'd0,
		CMD_EVAL  = 2'd1,
		CMD_CLEAR = 2'd2
	} cmd_t;

	// One rule as held in a cell; addr and proto double as packet fields.
	typedef struct packed {
		logic [31:0] addr;
		logic [5:0]  pfx;
		logic [1:0]  proto;
		logic [15:0] plo;
		logic [15:0] phi;
		logic [14:0] rnum;
		logic        act;
	} rule_t;

	// Command travelling down the chain together with its partial result.
	typedef struct packed {
		cmd_t             cmd;
		logic             dir;
		logic [CNT_W-1:0] count;
		logic [15:0]      port;
		rule_t            rule;
		logic             status;
		logic             matched;
		logic             allowed;
		logic [14:0]      best;
	} flit_t;

	function automatic logic [31:0] prefix_mask(input logic [5:0] pfx);
		if (pfx >= FULL_PREFIX) begin
			return 32'hFFFF_FFFF;
		end
		return ~(32'hFFFF_FFFF >> pfx);
	endfunction

endpackage

// ===== hw/rtl/nacl_head.sv =====
// Admission stage: table fill counts, full check and launch into the chain.
module nacl_head
	import nacl_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  advance,
	input  logic  take,
	input  flit_t req,
	output logic  vld_o,
	output flit_t flit_o
);

	logic [CNT_W-1:0] in_used_q;
	logic [CNT_W-1:0] out_used_q;
	logic             vld_q;
	flit_t            flit_q;
	logic [CNT_W-1:0] sel_used;
	logic             full;
	flit_t            nxt;

	always_comb begin
		sel_used = req.dir ? out_used_q : in_used_q;
		full     = (sel_used >= CNT_W'(MAX_RULES));
		nxt          = req;
		nxt.count    = sel_used;
		nxt.status   = (req.cmd == CMD_ADD) && full;
		nxt.matched  = 1'b0;
		nxt.allowed  = 1'b0;
		nxt.best     = '0;
		if (req.rule.pfx > FULL_PREFIX) begin
			nxt.rule.pfx = FULL_PREFIX;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q      <= 1'b0;
			in_used_q  <= '0;
			out_used_q <= '0;
		end else if (advance) begin
			vld_q <= take;
			if (take) begin
				unique case (req.cmd)
					CMD_ADD: begin
						if (!full) begin
							if (req.dir) begin
								out_used_q <= out_used_q + CNT_W'(1);
							end else begin
								in_used_q <= in_used_q + CNT_W'(1);
							end
						end
					end
					CMD_CLEAR: begin
						in_used_q  <= '0;
						out_used_q <= '0;
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			flit_q <= nxt;
		end
	end

	assign vld_o  = vld_q;
	assign flit_o = flit_q;

endmodule

// ===== hw/rtl/nacl_cell.sv =====
// One chain cell: holds inbound and outbound rule of its slot, matches a passing packet.
module nacl_cell
	import nacl_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             advance,
	input  logic [IDX_W-1:0] cell_index,
	input  logic             vld_i,
	input  flit_t            flit_i,
	output logic             vld_o,
	output flit_t            flit_o
);

	rule_t            in_rule_q;
	rule_t            out_rule_q;
	logic             vld_q;
	flit_t            flit_q;
	rule_t            r;
	logic [CNT_W-1:0] slot;
	logic [31:0]      mask;
	logic             proto_ok;
	logic             port_ok;
	logic             addr_ok;
	logic             better;
	logic             hit;
	logic             wr;
	flit_t            nxt;

	always_comb begin
		r        = flit_i.dir ? out_rule_q : in_rule_q;
		slot     = CNT_W'(cell_index);
		mask     = prefix_mask(r.pfx);
		proto_ok = (r.proto == PROTO_ALL) || (r.proto == flit_i.rule.proto);
		port_ok  = (r.plo == 16'd0) || ((flit_i.port >= r.plo) && (flit_i.port <= r.phi));
		addr_ok  = ((flit_i.rule.addr & mask) == (r.addr & mask));
		better   = !flit_i.matched || (r.rnum < flit_i.best);
		hit      = vld_i && (flit_i.cmd == CMD_EVAL) && (slot < flit_i.count)
			&& better && proto_ok && port_ok && addr_ok;
		wr       = advance && vld_i && (flit_i.cmd == CMD_ADD) && !flit_i.status
			&& (slot == flit_i.count);
		nxt = flit_i;
		if (hit) begin
			nxt.matched = 1'b1;
			nxt.best    = r.rnum;
			nxt.allowed = r.act;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (advance) begin
			vld_q <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			flit_q <= nxt;
		end
		if (wr && flit_i.dir) begin
			out_rule_q <= flit_i.rule;
		end
		if (wr && !flit_i.dir) begin
			in_rule_q <= flit_i.rule;
		end
	end

	assign vld_o  = vld_q;
	assign flit_o = flit_q;

endmodule

// ===== hw/rtl/network_acl_rule_classifier_unit.sv =====
// Top level of the ACL rule classifier: admission stage and chain of rule cells.
//
// Commands enter on the slave stream and pass through a head stage and then
// a row of MAX_RULES cells, one cell per cycle while the chain advances; cell i
// keeps rule i of the inbound table and rule i of the outbound table. The input
// transfer loads the head register and each advance moves the command one cell
// on, and the chain takes one new command in every cycle that it advances, so
// the sustained rate is one transfer per cycle while the output is not stalled.
// An add carries the fill count of its table and is written by the cell whose
// slot equals that count; an evaluate carries the same count, compares against
// each cell below it and keeps the lowest rule number seen so far, so earlier
// rules win ties. A clear resets both counts in the head at once. Commands are
// processed strictly in order, and each produces exactly one result. The
// whole chain advances only while the output register is empty or taken, so
// backpressure on the master side stalls the slave side in the same cycle.
// Rule storage has no reset; only slots below a table's count are consulted.
module network_acl_rule_classifier_unit
	import nacl_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// [1:0] protocol, [17:2] port, [49:18] address, [55:50] pfx_bits,
	// [70:56] rule_prio, [71] action, [87:72] port_low, [103:88] port_high
	input  logic [103:0] s_tdata,
	// [1:0] command, [2] direction
	input  logic [2:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// [0] status, [1] allowed, [2] matched, [17:3] matched rule priority,
	// [23:18] zero
	output logic [23:0]  m_tdata
);

	logic  advance;
	logic  take;
	flit_t req;
	logic  vld  [0:MAX_RULES];
	flit_t flit [0:MAX_RULES];

	// Advance the chain whenever the tail slot is free or being emptied.
	assign advance  = !vld[MAX_RULES] || m_tready;
	assign s_tready = advance;
	assign take     = s_tvalid && advance;

	// Unpack the input transfer; result fields are filled in by the head.
	always_comb begin
		req            = '0;
		req.cmd        = cmd_t'(s_tuser[1:0]);
		req.dir        = s_tuser[2];
		req.rule.proto = s_tdata[1:0];
		req.port       = s_tdata[17:2];
		req.rule.addr  = s_tdata[49:18];
		req.rule.pfx   = s_tdata[55:50];
		req.rule.rnum  = s_tdata[70:56];
		req.rule.act   = s_tdata[71];
		req.rule.plo   = s_tdata[87:72];
		req.rule.phi   = s_tdata[103:88];
	end

	nacl_head u_head (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.take    (take),
		.req     (req),
		.vld_o   (vld[0]),
		.flit_o  (flit[0])
	);

	for (genvar i = 0; i < MAX_RULES; i++) begin : g_cell
		nacl_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.advance    (advance),
			.cell_index (IDX_W'(i)),
			.vld_i      (vld[i]),
			.flit_i     (flit[i]),
			.vld_o      (vld[i+1]),
			.flit_o     (flit[i+1])
		);
	end

	// The last cell's register is the output register.
	assign m_tvalid = vld[MAX_RULES];
	assign m_tdata  = {6'd0, flit[MAX_RULES].best, flit[MAX_RULES].matched,
		flit[MAX_RULES].allowed, flit[MAX_RULES].status};

endmodule

// ===== hw/rtl/nacl_checker.sv =====
// Port-level checker of the ACL rule classifier and its bind.
`include "network_acl_rule_classifier_unit_defines.svh"

module nacl_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_tvalid,
	input logic         s_tready,
	input logic [103:0] s_tdata,
	input logic [2:0]   s_tuser,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [23:0]  m_tdata
);

	`NACL_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")
	`NACL_ASSERT_NEXT(a_out_stable, m_tvalid && !m_tready, $stable(m_tdata), "result changed while stalled")
	`NACL_ASSERT_NOW(a_stall_in, m_tvalid && !m_tready, !s_tready, "input taken while output stalled")
	`NACL_ASSERT_NOW(a_status_excl, m_tvalid && m_tdata[0], !m_tdata[2] && !m_tdata[1], "full status on a match")
	`NACL_ASSERT_NOW(a_nomatch_zero, m_tvalid && !m_tdata[2], m_tdata[17:1] == 17'd0, "result set without a match")

endmodule

bind network_acl_rule_classifier_unit nacl_checker u_nacl_checker (.*);

// ===== sim/network_acl_rule_classifier_unit_tb.sv =====
// Self-checking stream testbench for the ACL rule classifier, with its own rule-table predictor.
`timescale 1ns / 100ps

module network_acl_rule_classifier_unit_tb;
	import nacl_pkg::*;

	// Command code the block must ignore (no table change, all-zero result).
	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam logic [1:0] PROTO_TCP  = 2'd0;
	localparam logic [1:0] PROTO_UDP  = 2'd1;
	localparam logic [1:0] PROTO_ICMP = 2'd2;
	localparam logic       DIR_IN     = 1'b0;
	localparam logic       DIR_OUT    = 1'b1;
	localparam int         IDLE_PCT   = 31;
	localparam int         STIM_ITEMS = 1200;
	localparam int         TAIL_CYCLES = 2 * MAX_RULES + 8;

	// One command as offered on the slave stream; drain holds it back until
	// every earlier command has delivered its result.
	typedef struct packed {
		logic [1:0]  cmd;
		logic        dir;
		logic [15:0] port;
		rule_t       r;
		logic        drain;
	} acl_item_t;

	// Result word as laid out on m_tdata, lowest field last.
	typedef struct packed {
		logic [5:0]  pad;
		logic [14:0] rnum;
		logic        matched;
		logic        allowed;
		logic        status;
	} verdict_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [103:0] s_tdata = '0;
	logic [2:0]   s_tuser = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [23:0]  m_tdata;

	network_acl_rule_classifier_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Hard stop in case a result never shows up.
	initial begin
		#3_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	// ---------------------------------------------------------------------
	// Predictor: both rule tables as the block should hold them.
	// ---------------------------------------------------------------------
	rule_t       acl_tbl [2][MAX_RULES];
	int unsigned acl_fill [2];

	// Apply one accepted command to the tables and return its result.
	function automatic verdict_t classify(input acl_item_t it);
		verdict_t    v;
		rule_t       r;
		logic [31:0] m;
		logic        t;
		v = '0;
		t = it.dir;
		case (it.cmd)
			CMD_ADD: begin
				if (acl_fill[t] >= MAX_RULES) begin
					v.status = 1'b1;
				end else begin
					r = it.r;
					if (r.pfx > 6'd32) r.pfx = 6'd32;
					acl_tbl[t][IDX_W'(acl_fill[t])] = r;
					acl_fill[t]++;
				end
			end
			CMD_EVAL: begin
				// Scan in insertion order; only a strictly lower number replaces
				// the current winner, so the earlier rule keeps a tie.
				for (int i = 0; i < acl_fill[t]; i++) begin
					r = acl_tbl[t][IDX_W'(i)];
					m = (r.pfx == 6'd0) ? 32'h0 : (32'hFFFF_FFFF << (6'd32 - r.pfx));
					if (!(v.matched && r.rnum >= v.rnum) &&
					    (r.proto == PROTO_ALL || r.proto == it.r.proto) &&
					    (r.plo == 16'd0 || (it.port >= r.plo && it.port <= r.phi)) &&
					    ((it.r.addr & m) == (r.addr & m))) begin
						v.matched = 1'b1;
						v.rnum    = r.rnum;
						v.allowed = r.act;
					end
				end
			end
			CMD_CLEAR: begin
				acl_fill[0] = 0;
				acl_fill[1] = 0;
			end
			default: ;
		endcase
		return v;
	endfunction

	// ---------------------------------------------------------------------
	// Stimulus generation. The generator keeps its own copy of the rules it
	// has added, only to aim packets at them.
	// ---------------------------------------------------------------------
	acl_item_t   pending_q [$];
	verdict_t    verdict_q [$];
	rule_t       aim_tbl [2][MAX_RULES];
	int unsigned aim_fill [2];
	int          stim_cnt = 0;

	task automatic push_item(input acl_item_t it);
		pending_q.push_back(it);
		if (it.cmd != CMD_UNUSED) stim_cnt++;
		if (it.cmd == CMD_ADD && aim_fill[it.dir] < MAX_RULES) begin
			aim_tbl[it.dir][IDX_W'(aim_fill[it.dir])] = it.r;
			aim_fill[it.dir]++;
		end else if (it.cmd == CMD_CLEAR) begin
			aim_fill[0] = 0;
			aim_fill[1] = 0;
		end
	endtask

	task automatic push_fields(input logic [1:0] cmd, input logic dir, input logic [1:0] proto,
			input logic [15:0] port, input logic [31:0] addr, input logic [5:0] pfx,
			input logic [14:0] rnum, input logic act, input logic [15:0] plo,
			input logic [15:0] phi);
		acl_item_t it;
		it = '0;
		it.cmd     = cmd;
		it.dir     = dir;
		it.port    = port;
		it.r.proto = proto;
		it.r.addr  = addr;
		it.r.pfx   = pfx;
		it.r.rnum  = rnum;
		it.r.act   = act;
		it.r.plo   = plo;
		it.r.phi   = phi;
		push_item(it);
	endtask

	function automatic rule_t random_rule();
		rule_t r;
		r.addr  = $urandom;
		r.pfx   = ($urandom_range(9) == 0) ? 6'($urandom_range(63, 33)) : 6'($urandom_range(32));
		r.proto = 2'($urandom_range(3));
		r.plo   = ($urandom_range(9) < 3) ? 16'd0 : 16'($urandom);
		case ($urandom_range(3))
			0: r.phi = 16'($urandom);
			1: r.phi = 16'hFFFF;
			default: r.phi = r.plo + 16'($urandom_range(200)); // may wrap into an inverted range
		endcase
		// Small numbers half the time so ties and reordering are frequent.
		r.rnum = $urandom_range(1) ? 15'($urandom_range(15)) : 15'($urandom);
		r.act  = 1'($urandom_range(1));
		return r;
	endfunction

	function automatic acl_item_t random_packet(input logic dir);
		acl_item_t it;
		rule_t     g;
		it = '0;
		it.cmd  = CMD_EVAL;
		it.dir  = dir;
		it.r    = random_rule();
		it.port = 16'($urandom);
		// Aim most packets at a stored rule, with one address bit sometimes flipped.
		if (aim_fill[dir] != 0 && $urandom_range(9) < 7) begin
			g = aim_tbl[dir][IDX_W'($urandom_range(aim_fill[dir] - 1))];
			it.r.addr = g.addr;
			if ($urandom_range(1)) it.r.addr[5'($urandom_range(31))] ^= 1'b1;
			if (g.proto != PROTO_ALL && $urandom_range(7) != 0) it.r.proto = g.proto;
			if (g.plo != 16'd0 && g.plo <= g.phi) begin
				case ($urandom_range(3))
					0: it.port = g.plo;
					1: it.port = g.phi;
					default: it.port = g.plo + 16'($urandom_range(32'(g.phi - g.plo)));
				endcase
			end
		end
		return it;
	endfunction

	task automatic build_stimulus();
		acl_item_t it;
		logic      d;
		int        n_add;
		int        n_eval;
		int        ep;
		// Directed: empty table, ignored command, ties, saturated prefix,
		// inverted range, catch-all, protocol "all" packets, rule number zero.
		push_fields(CMD_EVAL, DIR_IN, PROTO_TCP, 16'd80, 32'hC0A8_0105, 6'd0, 15'd0, 1'b0,
			16'd0, 16'd0);
		push_fields(CMD_UNUSED, DIR_OUT, 2'd3, 16'hFFFF, 32'hFFFF_FFFF, 6'd63, 15'h7FFF, 1'b1,
			16'hFFFF, 16'hFFFF);
		push_fields(CMD_ADD, DIR_IN, PROTO_TCP, 16'd0, 32'hC0A8_0100, 6'd24, 15'd100, 1'b1,
			16'd80, 16'd80);
		push_fields(CMD_ADD, DIR_IN, PROTO_ALL, 16'd0, 32'hC0A8_0105, 6'd63, 15'd100, 1'b0,
			16'd0, 16'd5);
		push_fields(CMD_ADD, DIR_IN, PROTO_UDP, 16'd0, 32'h0000_0000, 6'd0, 15'd50, 1'b0,
			16'd1000, 16'd10);
		push_fields(CMD_ADD, DIR_IN, PROTO_ALL, 16'd0, 32'hDEAD_BEEF, 6'd0, 15'h7FFF, 1'b1,
			16'd0, 16'hFFFF);
		push_fields(CMD_ADD, DIR_OUT, PROTO_ICMP, 16'd0, 32'hFFFF_FFFF, 6'd32, 15'd0, 1'b1,
			16'hFFFF, 16'hFFFF);
		push_fields(CMD_EVAL, DIR_IN, PROTO_TCP, 16'd80, 32'hC0A8_0105, 6'd0, 15'd0, 1'b0,
			16'd0, 16'd0);
		push_fields(CMD_EVAL, DIR_IN, PROTO_UDP, 16'd500, 32'h0000_0000, 6'd0, 15'd0, 1'b0,
			16'd0, 16'd0);
		push_fields(CMD_EVAL, DIR_IN, PROTO_ALL, 16'd0, 32'hC0A8_0105, 6'd0, 15'd0, 1'b0,
			16'd0, 16'd0);
		push_fields(CMD_EVAL, DIR_IN, PROTO_ALL, 16'd80, 32'hC0A8_0106, 6'd0, 15'd0, 1'b0,
			16'd0, 16'd0);
		push_fields(CMD_EVAL, DIR_OUT, PROTO_ICMP, 16'hFFFF, 32'hFFFF_FFFF, 6'd0, 15'd0, 1'b0,
			16'd0, 16'd0);
		push_fields(CMD_EVAL, DIR_OUT, PROTO_ICMP, 16'hFFFE, 32'hFFFF_FFFF, 6'd0, 15'd0, 1'b0,
			16'd0, 16'd0);
		push_fields(CMD_EVAL, DIR_OUT, PROTO_TCP, 16'hFFFF, 32'hFFFF_FFFF, 6'd0, 15'd0, 1'b0,
			16'd0, 16'd0);
		push_fields(CMD_EVAL, DIR_IN, PROTO_TCP, 16'hFFFF, 32'hFFFF_FFFF, 6'd0, 15'd0, 1'b0,
			16'd0, 16'd0);
		push_fields(CMD_CLEAR, DIR_OUT, PROTO_TCP, 16'd0, 32'h0, 6'd0, 15'd0, 1'b0,
			16'd0, 16'd0);
		// Hold this clear until the block has emptied out.
		pending_q[$].drain = 1'b1;
		push_fields(CMD_EVAL, DIR_IN, PROTO_TCP, 16'd80, 32'hC0A8_0105, 6'd0, 15'd0, 1'b0,
			16'd0, 16'd0);
		push_fields(CMD_EVAL, DIR_OUT, PROTO_ICMP, 16'hFFFF, 32'hFFFF_FFFF, 6'd0, 15'd0, 1'b0,
			16'd0, 16'd0);

		// Random episodes: mostly a clear, a batch of adds (sometimes past
		// full), then aimed packets mixed with stray commands.
		ep = 0;
		while (stim_cnt < STIM_ITEMS) begin
			ep++;
			if ($urandom_range(2) != 0) begin
				it = '0;
				it.cmd   = CMD_CLEAR;
				it.dir   = 1'($urandom_range(1));
				it.port  = 16'($urandom);
				it.r     = random_rule();
				it.drain = (ep % 8 == 1);
				push_item(it);
			end
			d = 1'($urandom_range(1));
			n_add = ($urandom_range(4) == 0) ? $urandom_range(40, 30) : $urandom_range(1, 10);
			for (int i = 0; i < n_add; i++) begin
				it = '0;
				it.cmd  = CMD_ADD;
				it.dir  = ($urandom_range(5) == 0) ? ~d : d;
				it.port = 16'($urandom);
				it.r    = random_rule();
				push_item(it);
			end
			n_eval = $urandom_range(20, 4);
			for (int i = 0; i < n_eval; i++) begin
				case ($urandom_range(19))
					0, 1: begin
						it = '0;
						it.cmd  = 2'($urandom_range(3));
						it.dir  = 1'($urandom_range(1));
						it.port = 16'($urandom);
						it.r    = random_rule();
					end
					2: begin
						it = '0;
						it.cmd  = CMD_ADD;
						it.dir  = 1'($urandom_range(1));
						it.port = 16'($urandom);
						it.r    = random_rule();
					end
					default: it = random_packet(($urandom_range(4) == 0) ? ~d : d);
				endcase
				push_item(it);
			end
		end
	endtask

	// ---------------------------------------------------------------------
	// Driver: offer queued commands on the slave stream.
	// ---------------------------------------------------------------------
	acl_item_t cur_item;
	int        sent_cnt = 0;
	int        got_cnt = 0;
	logic      calm;
	logic      offer;

	// A window of the run with no idling on either side.
	assign calm = (sent_cnt >= 700 && sent_cnt < 900);

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			s_tuser  <= '0;
		end else begin
			if (s_tvalid && s_tready) begin
				verdict_q.push_back(classify(cur_item));
				sent_cnt <= sent_cnt + 1;
			end
			if (!s_tvalid || s_tready) begin
				offer = (pending_q.size() != 0) && (calm || $urandom_range(99) >= IDLE_PCT);
				// Hold a draining command until the block has gone quiet.
				if (offer && pending_q[0].drain && verdict_q.size() != 0) offer = 1'b0;
				if (offer) begin
					cur_item = pending_q.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= {cur_item.r.phi, cur_item.r.plo, cur_item.r.act,
						cur_item.r.rnum, cur_item.r.pfx, cur_item.r.addr, cur_item.port,
						cur_item.r.proto};
					s_tuser  <= {cur_item.dir, cur_item.cmd};
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// ---------------------------------------------------------------------
	// Long receiver hold-off: lets the chain fill and push back on the input.
	// ---------------------------------------------------------------------
	logic hold_out;
	logic hold_done;
	int   hold_left;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_out  <= 1'b0;
			hold_done <= 1'b0;
			hold_left <= 0;
		end else if (!hold_done && got_cnt >= 400) begin
			hold_out  <= 1'b1;
			hold_done <= 1'b1;
			hold_left <= 300;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			if (hold_left == 1) hold_out <= 1'b0;
		end
	end

	// ---------------------------------------------------------------------
	// Monitor: take results and compare them with the oldest prediction.
	// ---------------------------------------------------------------------
	verdict_t got;
	verdict_t want;
	int       err_cnt = 0;

	task automatic report_mismatch(input string what, input verdict_t w, input verdict_t g);
		if (err_cnt < 10) begin
			$write("[%0t] mismatch on result %0d (%s): ", $realtime, got_cnt, what);
			$write("expected status=%0b allowed=%0b matched=%0b rule=%0d pad=%h, ",
				w.status, w.allowed, w.matched, w.rnum, w.pad);
			$display("got status=%0b allowed=%0b matched=%0b rule=%0d pad=%h",
				g.status, g.allowed, g.matched, g.rnum, g.pad);
		end
		err_cnt++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				got = m_tdata;
				if (verdict_q.size() == 0) begin
					report_mismatch("nothing pending", '0, got);
				end else begin
					want = verdict_q.pop_front();
					if (got.status !== want.status || got.allowed !== want.allowed ||
					    got.matched !== want.matched || got.rnum !== want.rnum ||
					    got.pad !== want.pad) begin
						report_mismatch("field differs", want, got);
					end
				end
				got_cnt <= got_cnt + 1;
			end
			m_tready <= !hold_out && (calm || $urandom_range(99) >= IDLE_PCT);
		end
	end

	// ---------------------------------------------------------------------
	// Run control: build the command list, wait for it to drain, report.
	// ---------------------------------------------------------------------
	initial begin
		acl_fill[0] = 0;
		acl_fill[1] = 0;
		aim_fill[0] = 0;
		aim_fill[1] = 0;
		build_stimulus();
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		// Sample between edges so the driver's updates of this cycle are seen.
		while (pending_q.size() != 0 || s_tvalid || verdict_q.size() != 0) @(negedge clk);
		// Give a stray extra result time to surface.
		repeat (TAIL_CYCLES) @(posedge clk);
		if (err_cnt == 0 && verdict_q.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
